@@ rtl/msadpcm_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// msadpcm_pkg
// Shared types, register codes and constants of the MS ADPCM block decoder.
// -----------------------------------------------------------------------------
package msadpcm_pkg;

   localparam int MAX_CHANNELS_DEF = 2;
   localparam int NUM_PREDICTORS   = 7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_NUM_CHANNELS      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLES_PER_BLOCK = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_PERCENT      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_COEFF_PAIRS_0_1   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_COEFF_PAIRS_2_3   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_COEFF_PAIRS_4_5   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_COEFF_PAIR_6      = 3'd6;

   // ceil(2^30 / 100): exact floor division by 100 for magnitudes below 2^23
   localparam logic [23:0] RECIP_100 = 24'd10737419;

   typedef struct packed {
      logic [1:0]        num_channels;
      logic [12:0]       samples_per_block;
      logic [6:0]        gain_percent;
      logic [3:0][63:0]  coeff_pairs;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASS,
      ST_MUL,
      ST_SUM,
      ST_UPD,
      ST_GAIN,
      ST_RECIP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic hdr_write;
      logic mul_en;
      logic sum_en;
      logic upd_en;
      logic gain_en;
      logic recip_en;
      logic out_load;
      logic next_nib;
   } cmd_type;

   typedef struct packed {
      logic is_header;
      logic hdr_emit;
      logic blocked;
      logic more;
      logic out_free;
   } status_type;

   // step adaptation factor, scaled by 256
   function automatic logic [9:0] adapt_factor(input logic [3:0] nib);
      logic [9:0] f;
      begin
         case (nib)
            4'd4, 4'd12: f = 10'd307;
            4'd5, 4'd11: f = 10'd409;
            4'd6, 4'd10: f = 10'd512;
            4'd7, 4'd9:  f = 10'd614;
            4'd8:        f = 10'd768;
            default:     f = 10'd230;
         endcase
         return f;
      end
   endfunction

endpackage
`default_nettype wire

@@ rtl/msadpcm_ifs.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// msadpcm_ifs
// Valid/ready channels of the decoder: data bytes in, samples out, register writes.
// -----------------------------------------------------------------------------
interface msadpcm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       block_start;

   modport source (output valid, data_byte, block_start, input ready);
   modport sink   (input valid, data_byte, block_start, output ready);
endinterface

interface msadpcm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               channel;
   logic               last_of_item;

   modport source (output valid, sample, channel, last_of_item, input ready);
   modport sink   (input valid, sample, channel, last_of_item, output ready);
endinterface

interface msadpcm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [msadpcm_pkg::CSR_INDEX_W-1:0] index;
   logic [msadpcm_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/msadpcm_csr.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// msadpcm_csr
// Configuration registers: channel count, block length, gain, predictor coefficients.
// -----------------------------------------------------------------------------
module msadpcm_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [msadpcm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [msadpcm_pkg::CSR_DATA_W-1:0]  csr_data,
   output msadpcm_pkg::cfg_type                     cfg
);

   msadpcm_pkg::cfg_type cfg_ff;

   assign csr_ready = !reset;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_channels      <= 2'd1;
         cfg_ff.samples_per_block <= 13'd2036;
         cfg_ff.gain_percent      <= 7'd100;
         cfg_ff.coeff_pairs       <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            msadpcm_pkg::REG_NUM_CHANNELS:
               cfg_ff.num_channels <= csr_data[1:0];
            msadpcm_pkg::REG_SAMPLES_PER_BLOCK:
               cfg_ff.samples_per_block <= csr_data[12:0];
            msadpcm_pkg::REG_GAIN_PERCENT:
               cfg_ff.gain_percent <= csr_data[6:0];
            msadpcm_pkg::REG_COEFF_PAIRS_0_1:
               cfg_ff.coeff_pairs[0] <= csr_data;
            msadpcm_pkg::REG_COEFF_PAIRS_2_3:
               cfg_ff.coeff_pairs[1] <= csr_data;
            msadpcm_pkg::REG_COEFF_PAIRS_4_5:
               cfg_ff.coeff_pairs[2] <= csr_data;
            msadpcm_pkg::REG_COEFF_PAIR_6:
               cfg_ff.coeff_pairs[3] <= {32'd0, csr_data[31:0]};
            default: begin
               // unused index: drop the write
            end
         endcase
      end
   end

endmodule
`default_nettype wire

@@ rtl/msadpcm_ctrl.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// msadpcm_ctrl
// Sequencer: steps each byte through header write or nibble decode and output.
// -----------------------------------------------------------------------------
module msadpcm_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire msadpcm_pkg::status_type status,
   output msadpcm_pkg::cmd_type         cmd
);

   msadpcm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msadpcm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         msadpcm_pkg::ST_IDLE: begin
            if (req_valid) state_in = msadpcm_pkg::ST_CLASS;
         end
         msadpcm_pkg::ST_CLASS: begin
            if (status.is_header) begin
               state_in = status.hdr_emit ? msadpcm_pkg::ST_GAIN : msadpcm_pkg::ST_IDLE;
            end else begin
               state_in = status.blocked ? msadpcm_pkg::ST_IDLE : msadpcm_pkg::ST_MUL;
            end
         end
         msadpcm_pkg::ST_MUL:   state_in = msadpcm_pkg::ST_SUM;
         msadpcm_pkg::ST_SUM:   state_in = msadpcm_pkg::ST_UPD;
         msadpcm_pkg::ST_UPD:   state_in = msadpcm_pkg::ST_GAIN;
         msadpcm_pkg::ST_GAIN:  state_in = msadpcm_pkg::ST_RECIP;
         msadpcm_pkg::ST_RECIP: state_in = msadpcm_pkg::ST_OUT;
         msadpcm_pkg::ST_OUT: begin
            if (status.out_free) begin
               state_in = status.more ? msadpcm_pkg::ST_MUL : msadpcm_pkg::ST_IDLE;
            end
         end
         default: state_in = msadpcm_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         msadpcm_pkg::ST_IDLE: begin
            req_ready = !reset;
            cmd.load  = req_valid && !reset;
         end
         msadpcm_pkg::ST_CLASS: cmd.hdr_write = status.is_header;
         msadpcm_pkg::ST_MUL:   cmd.mul_en    = 1'b1;
         msadpcm_pkg::ST_SUM:   cmd.sum_en    = 1'b1;
         msadpcm_pkg::ST_UPD:   cmd.upd_en    = 1'b1;
         msadpcm_pkg::ST_GAIN:  cmd.gain_en   = 1'b1;
         msadpcm_pkg::ST_RECIP: cmd.recip_en  = 1'b1;
         msadpcm_pkg::ST_OUT: begin
            cmd.out_load = status.out_free;
            cmd.next_nib = status.out_free && status.more;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/msadpcm_dp.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// msadpcm_dp
// Datapath: channel state, header parsing, predictor, step update, gain, output.
// -----------------------------------------------------------------------------
module msadpcm_dp #(
   parameter int MAX_CHANNELS = msadpcm_pkg::MAX_CHANNELS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire msadpcm_pkg::cfg_type cfg,
   input  wire msadpcm_pkg::cmd_type cmd,
   output msadpcm_pkg::status_type   status,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_block_start,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic signed [15:0]        rsp_sample,
   output logic                      rsp_channel,
   output logic                      rsp_last_of_item
);

   localparam int ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // per-channel decoder state
   logic [7:0]         pidx_ff  [MAX_CHANNELS];
   logic signed [31:0] step_ff  [MAX_CHANNELS];
   logic signed [15:0] prev_ff  [MAX_CHANNELS];
   logic signed [15:0] prev2_ff [MAX_CHANNELS];

   logic [3:0]  hdr_cnt_ff;
   logic [13:0] emitted_ff;
   logic [7:0]  byte_ff;
   logic        k_ff;
   logic        item_data_ff;

   // arithmetic pipeline registers
   logic signed [31:0] prod1_ff, prod2_ff;
   logic signed [35:0] pstep_ff;
   logic signed [42:0] pns_ff;
   logic signed [24:0] pred_ff;
   logic signed [31:0] ns_ff;
   logic signed [15:0] src_ff;
   logic [ChW-1:0]     chan_ff;
   logic signed [23:0] gp_ff;
   logic [46:0]        rq_ff;
   logic               neg_ff;

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_sample_ff;
   logic               rsp_channel_ff;
   logic               rsp_last_ff;

   // block geometry
   logic        stereo;
   logic [3:0]  hlen;
   logic [13:0] limit;
   logic        is_header, blocked, more, out_free;

   assign stereo    = (MAX_CHANNELS >= 2) && cfg.num_channels[1];
   assign hlen      = stereo ? 4'd14 : 4'd7;
   assign limit     = stereo ? {cfg.samples_per_block, 1'b0} : {1'b0, cfg.samples_per_block};
   assign is_header = hdr_cnt_ff < hlen;
   assign blocked   = emitted_ff >= limit;
   assign more      = item_data_ff && !k_ff && !blocked;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // header position decode
   logic [3:0]     hoff;
   logic           is_pidx;
   logic [1:0]     region;
   logic           hi;
   logic [ChW-1:0] hch, pch;
   logic [7:0]     lo_sel;
   logic           hdr_emit;

   assign hoff    = stereo ? (hdr_cnt_ff - 4'd2) : (hdr_cnt_ff - 4'd1);
   assign is_pidx = stereo ? (hdr_cnt_ff < 4'd2) : (hdr_cnt_ff == 4'd0);
   assign region  = stereo ? hoff[3:2] : hoff[2:1];
   assign hi      = hoff[0];
   assign hch     = ChW'(stereo ? hoff[1] : 1'b0);
   assign pch     = ChW'(stereo ? hdr_cnt_ff[0] : 1'b0);

   always_comb begin
      case (region)
         2'd0:    lo_sel = step_ff[hch][7:0];
         2'd1:    lo_sel = prev_ff[hch][7:0];
         default: lo_sel = prev2_ff[hch][7:0];
      endcase
   end

   assign hdr_emit = !is_pidx && hi && (region != 2'd0);

   // nibble operands
   logic [ChW-1:0]     dch;
   logic [3:0]         nib;
   logic [7:0]         pk;
   logic               coeff_ok;
   logic [31:0]        cword;
   logic signed [15:0] c1, c2;
   logic signed [3:0]  snib;
   logic signed [10:0] adapt;

   assign dch      = ChW'(stereo ? k_ff : 1'b0);
   assign nib      = k_ff ? byte_ff[3:0] : byte_ff[7:4];
   assign pk       = pidx_ff[dch];
   assign coeff_ok = pk < 8'(msadpcm_pkg::NUM_PREDICTORS);
   assign cword    = !coeff_ok ? 32'd0
                   : (pk[0] ? cfg.coeff_pairs[pk[2:1]][63:32]
                            : cfg.coeff_pairs[pk[2:1]][31:0]);
   assign c1       = cword[15:0];
   assign c2       = cword[31:16];
   assign snib     = nib;
   assign adapt    = {1'b0, msadpcm_pkg::adapt_factor(nib)};

   // prediction and step, truncated toward zero
   logic signed [32:0] sum_w, sum_b;
   logic signed [42:0] ns_b;
   logic signed [34:0] ns_q;
   logic signed [31:0] ns_w;

   assign sum_w = {prod1_ff[31], prod1_ff} + {prod2_ff[31], prod2_ff};
   assign sum_b = sum_w + (sum_w[32] ? 33'sd255 : 33'sd0);
   assign ns_b  = pns_ff + (pns_ff[42] ? 43'sd255 : 43'sd0);
   assign ns_q  = ns_b[42:8];

   always_comb begin
      if (ns_q < 35'sd16) begin
         ns_w = 32'sd16;
      end else if (ns_q > 35'sd2147483647) begin
         ns_w = 32'sh7FFFFFFF;
      end else begin
         ns_w = ns_q[31:0];
      end
   end

   // new sample
   logic signed [36:0] nv_w;
   logic signed [15:0] nv_clamp;

   assign nv_w = {{12{pred_ff[24]}}, pred_ff} + {pstep_ff[35], pstep_ff};

   always_comb begin
      if (nv_w > 37'sd32767) begin
         nv_clamp = 16'sh7FFF;
      end else if (nv_w < -37'sd32768) begin
         nv_clamp = 16'sh8000;
      end else begin
         nv_clamp = nv_w[15:0];
      end
   end

   // gain: magnitude times reciprocal of 100, then sign and clamp
   logic [22:0]        mag_w;
   logic [16:0]        q_w;
   logic signed [15:0] scaled;

   assign mag_w = gp_ff[23] ? 23'(-gp_ff) : gp_ff[22:0];
   assign q_w   = rq_ff[46:30];

   always_comb begin
      if (!neg_ff) begin
         scaled = (q_w > 17'd32767) ? 16'sh7FFF : q_w[15:0];
      end else begin
         scaled = (q_w > 17'd32768) ? 16'sh8000 : 16'(-q_w);
      end
   end

   // control-side registers and channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff   <= '0;
         emitted_ff   <= '0;
         k_ff         <= 1'b0;
         item_data_ff <= 1'b0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            pidx_ff[i]  <= '0;
            step_ff[i]  <= '0;
            prev_ff[i]  <= '0;
            prev2_ff[i] <= '0;
         end
      end else begin
         if (cmd.load) begin
            k_ff         <= 1'b0;
            item_data_ff <= 1'b1;
            if (req_block_start) begin
               hdr_cnt_ff <= '0;
               emitted_ff <= '0;
            end
         end
         if (cmd.hdr_write) begin
            item_data_ff <= 1'b0;
            hdr_cnt_ff   <= hdr_cnt_ff + 4'd1;
            if (is_pidx) begin
               pidx_ff[pch] <= byte_ff;
            end else begin
               case (region)
                  2'd0: step_ff[hch] <= hi ? 32'($signed({byte_ff, lo_sel}))
                                           : {24'd0, byte_ff};
                  2'd1: prev_ff[hch] <= hi ? {byte_ff, lo_sel} : {8'd0, byte_ff};
                  default: prev2_ff[hch] <= hi ? {byte_ff, lo_sel} : {8'd0, byte_ff};
               endcase
               if (hdr_emit && (emitted_ff != 14'h3FFF)) begin
                  emitted_ff <= emitted_ff + 14'd1;
               end
            end
         end
         if (cmd.upd_en) begin
            prev2_ff[dch] <= prev_ff[dch];
            prev_ff[dch]  <= nv_clamp;
            step_ff[dch]  <= ns_ff;
            emitted_ff    <= emitted_ff + 14'd1;
         end
         if (cmd.next_nib) begin
            k_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= req_data_byte;
      end
      if (cmd.hdr_write) begin
         src_ff  <= {byte_ff, lo_sel};
         chan_ff <= hch;
      end
      if (cmd.mul_en) begin
         prod1_ff <= prev_ff[dch] * c1;
         prod2_ff <= prev2_ff[dch] * c2;
         pstep_ff <= step_ff[dch] * snib;
         pns_ff   <= step_ff[dch] * adapt;
      end
      if (cmd.sum_en) begin
         pred_ff <= sum_b[32:8];
         ns_ff   <= ns_w;
      end
      if (cmd.upd_en) begin
         src_ff  <= nv_clamp;
         chan_ff <= dch;
      end
      if (cmd.gain_en) begin
         gp_ff <= src_ff * $signed({1'b0, cfg.gain_percent});
      end
      if (cmd.recip_en) begin
         rq_ff  <= mag_w * msadpcm_pkg::RECIP_100;
         neg_ff <= gp_ff[23];
      end
      if (cmd.out_load) begin
         rsp_sample_ff  <= scaled;
         rsp_channel_ff <= chan_ff[0];
         rsp_last_ff    <= !more;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample       = rsp_sample_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_last_of_item = rsp_last_ff;

   assign status.is_header = is_header;
   assign status.hdr_emit  = hdr_emit;
   assign status.blocked   = blocked;
   assign status.more      = more;
   assign status.out_free  = out_free;

endmodule
`default_nettype wire

@@ rtl/ms_adpcm_block_decoder_top.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// ms_adpcm_block_decoder_top
// Microsoft ADPCM block decoder, one data byte in, up to two samples out.
// -----------------------------------------------------------------------------
// Feed the ADPCM data chunk one byte per req beat and raise block_start on the
// first header byte of each block. Header bytes (predictor index, step, sample 1,
// sample 2 per channel, little endian) load the channel state; each completed
// header sample comes out as its own rsp beat. Every data byte after the header
// gives one sample per nibble, high nibble first: both for channel 0 in mono,
// channel 0 then 1 in stereo, with last_of_item on the final beat of the byte.
// Once samples_per_block * channels samples have come out, further bytes give
// no beat. All samples are scaled by gain_percent / 100. The block takes one
// byte at a time: each byte is loaded and classified; a header byte that
// completes a sample then passes the gain, reciprocal and output steps, and a
// data byte passes the multiply, sum, update, gain, reciprocal and output steps
// once per decoded nibble; rsp back-pressure holds the output step. Write the
// csr registers only while the block is idle.
// -----------------------------------------------------------------------------
module ms_adpcm_block_decoder_top #(
   parameter int MAX_CHANNELS = msadpcm_pkg::MAX_CHANNELS_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   msadpcm_req_if.sink    req_bus,
   msadpcm_rsp_if.source  rsp_bus,
   msadpcm_csr_if.sink    csr_bus
);

   msadpcm_pkg::cfg_type    cfg;
   msadpcm_pkg::cmd_type    cmd;
   msadpcm_pkg::status_type status;

   // configuration registers
   msadpcm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_bus.valid),
      .csr_ready (csr_bus.ready),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .cfg       (cfg)
   );

   // sequencer: owns the req handshake, advances one step per cycle unless idle or held by rsp back-pressure
   msadpcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: holds channel state and drives the rsp output register
   msadpcm_dp #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_data_byte    (req_bus.data_byte),
      .req_block_start  (req_bus.block_start),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_sample       (rsp_bus.sample),
      .rsp_channel      (rsp_bus.channel),
      .rsp_last_of_item (rsp_bus.last_of_item)
   );

endmodule
`default_nettype wire

@@ rtl/msadpcm_checker.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// msadpcm_checker
// Port-level checks of the decoder's handshakes, bound to the top level.
// -----------------------------------------------------------------------------
module msadpcm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_last
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // one byte at a time: no new byte right after an accepted one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted in back-to-back cycles");

   // a byte with more samples to come blocks the input
   a_last_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |-> !req_ready)
      else $error("req ready before final sample of a byte");

   // a sample never appears in the cycle right after a byte is taken
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("rsp beat too early after req beat");

endmodule

bind ms_adpcm_block_decoder_top msadpcm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_last  (rsp_bus.last_of_item)
);
`default_nettype wire
